// ----- rtl/core/crb_pkg.sv -----
// ----------------------------------------------------------------------------
// crb_pkg
// shared types and constants of the chunk ring buffer
// ----------------------------------------------------------------------------
package crb_pkg;

  // ring geometry
  localparam int NUM_SLOTS   = 16;
  localparam int CHUNK_BYTES = 32;
  localparam int PTR_W       = $clog2(NUM_SLOTS);
  localparam int OFF_W       = $clog2(CHUNK_BYTES);
  localparam int MEM_DEPTH   = NUM_SLOTS * CHUNK_BYTES;

  // field widths
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int RLIM_W  = 8;
  localparam int STAT_W  = 3;
  localparam int LEN_W   = 6;
  localparam int CAP_W   = 5;
  localparam int FILL_W  = 4;
  localparam int CFG_W   = 6;
  localparam int CIDX_W  = 2;

  // register indexes of the configuration port
  localparam logic [CIDX_W-1:0] REG_LINK_UP      = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SLOTS_IN_USE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_CHUNK_LIMIT  = 2'd2;

  // register reset values
  localparam logic [CAP_W-1:0] SLOTS_RESET = 5'd16;
  localparam logic [LEN_W-1:0] LIMIT_RESET = 6'd32;

  // operation codes; the unused code answers as a query
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_CONN  = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_BAD_LIMIT = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PRIME,
    S_STREAM,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // capture the request fields
    logic exec_write;  // write beat step
    logic exec_read;   // read checks, pointer advance
    logic exec_query;  // status query
    logic rd_issue;    // fetch the next chunk byte
    logic load_status; // single status result
    logic load_byte;   // one chunk byte result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            read_go;  // read passes its checks and has bytes
    logic            idx_last; // byte in flight is the last one
    logic            out_free; // result register can take a new result
  } stat_t;

endpackage

// ----- rtl/core/crb_ctrl.sv -----
// ----------------------------------------------------------------------------
// crb_ctrl
// sequencer of one request: execute, then emit a status or stream bytes
// ----------------------------------------------------------------------------
module crb_ctrl
  import crb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = rst || (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.op == OP_WRITE) begin
          cmd.exec_write = 1'b1;
          state_next     = S_RESULT;
        end else if (st.op == OP_READ) begin
          cmd.exec_read = 1'b1;
          state_next    = st.read_go ? S_PRIME : S_RESULT;
        end else begin
          cmd.exec_query = 1'b1;
          state_next     = S_RESULT;
        end
      end
      S_PRIME: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_STREAM;
      end
      S_STREAM: begin
        if (st.out_free) begin
          cmd.load_byte = 1'b1;
          if (st.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
          end
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.load_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/crb_datapath.sv -----
// ----------------------------------------------------------------------------
// crb_datapath
// registers, pointers, chunk memory, length store and result register
// ----------------------------------------------------------------------------
module crb_datapath
  import crb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [OP_W-1:0]     op,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                beat_valid,
  input  logic                beat_last,
  input  logic [RLIM_W-1:0]   read_limit,
  input  cmd_t                cmd,
  output stat_t               st,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [STAT_W-1:0]   status,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_valid,
  output logic                out_last,
  output logic [LEN_W-1:0]    bytes_returned,
  output logic [FILL_W-1:0]   fill_level,
  output logic                empty_flag,
  output logic                full_flag
);

  // configuration
  logic             link_up;
  logic [CAP_W-1:0] slots_in_use;
  logic [LEN_W-1:0] chunk_limit;

  // ring state
  logic [PTR_W-1:0] write_pointer, read_pointer;
  logic [LEN_W-1:0] beat_count;
  logic             chunk_overflow;

  // captured request
  logic [OP_W-1:0]   op_q;
  logic [BYTE_W-1:0] data_q;
  logic              bvalid_q, blast_q;
  logic [RLIM_W-1:0] rlim_q;

  // read in flight
  logic [PTR_W-1:0] base;
  logic [OFF_W-1:0] idx, idx_next;
  logic [LEN_W-1:0] n_q;
  logic [BYTE_W-1:0] rd_data;
  status_t          item_status;

  // stores
  logic [BYTE_W-1:0] mem [MEM_DEPTH];
  logic [LEN_W-1:0]  slot_length [NUM_SLOTS];

  // result register
  status_t           r_status;
  logic [BYTE_W-1:0] r_byte;
  logic              r_ovalid, r_last;
  logic [LEN_W-1:0]  r_total;

  logic [CAP_W-1:0] cap, wp_ext, rp_ext, fill;
  logic [PTR_W-1:0] wp_inc, rp_inc;
  logic             ring_full, ring_empty;
  logic [LEN_W-1:0] lim, bc_new, len_rp, n;
  logic             take_byte, ovf_new;
  status_t          wstatus, rstatus;

  // ring arithmetic, capacity clamped to one..NUM_SLOTS
  always_comb begin
    if (slots_in_use == '0) begin
      cap = CAP_W'(1);
    end else if (slots_in_use > CAP_W'(NUM_SLOTS)) begin
      cap = CAP_W'(NUM_SLOTS);
    end else begin
      cap = slots_in_use;
    end
    wp_ext     = {{(CAP_W-PTR_W){1'b0}}, write_pointer};
    rp_ext     = {{(CAP_W-PTR_W){1'b0}}, read_pointer};
    wp_inc     = (wp_ext + CAP_W'(1) == cap) ? '0 : write_pointer + PTR_W'(1);
    rp_inc     = (rp_ext + CAP_W'(1) == cap) ? '0 : read_pointer + PTR_W'(1);
    ring_full  = (wp_inc == read_pointer);
    ring_empty = (write_pointer == read_pointer);
    fill       = (wp_ext >= rp_ext) ? (wp_ext - rp_ext) : (wp_ext + cap - rp_ext);
  end

  // write beat
  always_comb begin
    lim       = (chunk_limit < LEN_W'(CHUNK_BYTES)) ? chunk_limit : LEN_W'(CHUNK_BYTES);
    take_byte = bvalid_q && (beat_count < lim);
    ovf_new   = chunk_overflow || (bvalid_q && !(beat_count < lim));
    bc_new    = take_byte ? beat_count + LEN_W'(1) : beat_count;
    if (!link_up) begin
      wstatus = ST_NOT_CONN;
    end else if (ovf_new) begin
      wstatus = ST_TOO_LONG;
    end else if (blast_q && ring_full) begin
      wstatus = ST_FULL;
    end else begin
      wstatus = ST_OK;
    end
  end

  // read checks; a stored length never exceeds the chunk size
  always_comb begin
    len_rp = slot_length[read_pointer];
    n      = ({{(RLIM_W-LEN_W){1'b0}}, len_rp} < rlim_q) ? len_rp : rlim_q[LEN_W-1:0];
    if (!link_up) begin
      rstatus = ST_NOT_CONN;
    end else if (rlim_q == '0) begin
      rstatus = ST_BAD_LIMIT;
    end else if (ring_empty) begin
      rstatus = ST_EMPTY;
    end else begin
      rstatus = ST_OK;
    end
  end

  assign idx_next = cmd.load_byte ? idx + OFF_W'(1) : idx;

  assign st.op       = op_q;
  assign st.read_go  = (rstatus == ST_OK) && (n != '0);
  assign st.idx_last = ({{(LEN_W-OFF_W){1'b0}}, idx} + LEN_W'(1) == n_q);
  assign st.out_free = !res_valid || !res_stall;

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link_up        <= 1'b0;
      slots_in_use   <= SLOTS_RESET;
      chunk_limit    <= LIMIT_RESET;
      write_pointer  <= '0;
      read_pointer   <= '0;
      beat_count     <= '0;
      chunk_overflow <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (cmd.exec_write) begin
        if (blast_q) begin
          beat_count     <= '0;
          chunk_overflow <= 1'b0;
          if (wstatus == ST_OK) begin
            write_pointer <= wp_inc;
          end
        end else begin
          beat_count     <= bc_new;
          chunk_overflow <= ovf_new;
        end
      end
      if (cmd.exec_read && rstatus == ST_OK) begin
        read_pointer <= rp_inc;
      end
      if (cmd.load_status || cmd.load_byte) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LINK_UP: begin
            link_up <= cfg_data[0];
          end
          REG_SLOTS_IN_USE: begin
            slots_in_use   <= cfg_data[CAP_W-1:0];
            write_pointer  <= '0;
            read_pointer   <= '0;
            beat_count     <= '0;
            chunk_overflow <= 1'b0;
          end
          REG_CHUNK_LIMIT: begin
            chunk_limit <= cfg_data[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q     <= op;
      data_q   <= data_byte;
      bvalid_q <= beat_valid;
      blast_q  <= beat_last;
      rlim_q   <= read_limit;
    end
    if (cmd.exec_write) begin
      item_status <= wstatus;
    end
    if (cmd.exec_query) begin
      item_status <= ST_OK;
    end
    if (cmd.exec_read) begin
      item_status <= rstatus;
      n_q         <= n;
      base        <= read_pointer;
    end
    if (cmd.exec_read) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
    if (cmd.load_status) begin
      r_status <= item_status;
      r_byte   <= '0;
      r_ovalid <= 1'b0;
      r_last   <= 1'b1;
      r_total  <= '0;
    end
    if (cmd.load_byte) begin
      r_status <= ST_OK;
      r_byte   <= rd_data;
      r_ovalid <= 1'b1;
      r_last   <= st.idx_last;
      r_total  <= n_q;
    end
    if (cmd.load_status || cmd.load_byte) begin
      fill_level <= fill[FILL_W-1:0];
      empty_flag <= ring_empty;
      full_flag  <= ring_full;
    end
  end

  // chunk memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec_write && take_byte) begin
      mem[{write_pointer, beat_count[OFF_W-1:0]}] <= data_q;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[{base, idx_next}];
    end
  end

  // length store, written on a successful commit
  always_ff @(posedge clk) begin
    if (cmd.exec_write && blast_q && wstatus == ST_OK) begin
      slot_length[write_pointer] <= bc_new;
    end
  end

  assign status         = r_status;
  assign out_byte       = r_byte;
  assign out_valid      = r_ovalid;
  assign out_last       = r_last;
  assign bytes_returned = r_total;

endmodule

// ----- rtl/core/chunk_ring_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// chunk_ring_buffer_unit
// ring of fixed-size chunk slots with a per-slot length store
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   in_valid / in_stall    op, data_byte, beat_valid, beat_last, read_limit
//  result    res_valid / res_stall  status, out_byte, out_valid, out_last,
//                                   bytes_returned, fill_level, empty_flag, full_flag
//  config    cfg_we                 cfg_index, cfg_data
//
//  a write beat, a query or a refused read passes capture, execute and result load;
//  a read of n > 0 bytes passes capture, execute, a prime fetch and n byte loads, one byte
//  per cycle while res_stall is low, from the single read port of the chunk memory
//  the next request is taken while the last result still sits in the result register
//  res_stall holds the result register and pauses the byte stream
//  synchronous reset: link down, 16 slots, limit 32, ring empty; stores not cleared;
//  requests are stalled while reset is high
// ----------------------------------------------------------------------------
module chunk_ring_buffer_unit
  import crb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                beat_valid,
  input  logic                beat_last,
  input  logic [RLIM_W-1:0]   read_limit,
  // result channel
  output logic                res_valid,
  input  logic                res_stall,
  output logic [STAT_W-1:0]   status,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_valid,
  output logic                out_last,
  output logic [LEN_W-1:0]    bytes_returned,
  output logic [FILL_W-1:0]   fill_level,
  output logic                empty_flag,
  output logic                full_flag
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t st;

  // sequencer: idle, execute, then either one status result or a byte stream
  crb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // pointers, memories and the result register
  crb_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .data_byte      (data_byte),
    .beat_valid     (beat_valid),
    .beat_last      (beat_last),
    .read_limit     (read_limit),
    .cmd            (cmd),
    .st             (st),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .status         (status),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_last       (out_last),
    .bytes_returned (bytes_returned),
    .fill_level     (fill_level),
    .empty_flag     (empty_flag),
    .full_flag      (full_flag)
  );

endmodule
